[hw/rtl/crcfrc_pkg.sv]
// Shared types, constants and the byte-wide CRC-16 update for the frame checker.
`default_nettype none

package crcfrc_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CRC_W      = 16;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned POS_W      = 17;
	localparam int unsigned MINB_W     = 17;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [CRC_W-1:0]  CRC_INIT       = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY_RST   = 16'h1021;
	localparam logic [MINB_W-1:0] MIN_BYTES_RST  = 17'd6;
	localparam logic [POS_W-1:0]  FRAME_OVERHEAD = 17'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY = 2'd0,
		REG_PFX1 = 2'd1,
		REG_PFX2 = 2'd2,
		REG_MINB = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_PENDING = 3'd0,
		ST_OK      = 3'd1,
		ST_SHORT   = 3'd2,
		ST_PREFIX  = 3'd3,
		ST_CRC     = 3'd4
	} status_t;

	typedef struct packed {
		logic [CRC_W-1:0]  poly;
		logic [BYTE_W-1:0] pfx1;
		logic [BYTE_W-1:0] pfx2;
		logic [MINB_W-1:0] minb;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              payload_valid;
		logic              frame_done;
		status_t           frame_status;
	} result_t;

	// MSB-first CRC-16, one byte, no final xor
	function automatic logic [CRC_W-1:0] crc_feed(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] b,
		input logic [CRC_W-1:0]  poly
	);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1])
				c = {c[CRC_W-2:0], 1'b0} ^ poly;
			else
				c = {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/crcfrc_parser.sv]
// Frame parser: position tracking, length capture, CRC accumulation and status decision.
`default_nettype none

module crcfrc_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire crcfrc_pkg::cfg_t               cfg,
	input  wire logic                           step,
	input  wire logic [crcfrc_pkg::BYTE_W-1:0]  rx_byte,
	input  wire logic                           abort,
	output crcfrc_pkg::result_t                 res
);

	localparam logic [crcfrc_pkg::POS_W-1:0] POS_PFX1  = 17'd0;
	localparam logic [crcfrc_pkg::POS_W-1:0] POS_PFX2  = 17'd1;
	localparam logic [crcfrc_pkg::POS_W-1:0] POS_LENHI = 17'd2;
	localparam logic [crcfrc_pkg::POS_W-1:0] POS_LENLO = 17'd3;
	localparam logic [crcfrc_pkg::POS_W-1:0] POS_DATA  = 17'd4;

	logic [crcfrc_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [crcfrc_pkg::LEN_W-1:0]  len_q, len_d;
	logic [crcfrc_pkg::CRC_W-1:0]  crc_q, crc_d;
	logic                          match_q, match_d;
	logic [crcfrc_pkg::BYTE_W-1:0] crc_lo_q, crc_lo_d;

	logic [crcfrc_pkg::POS_W-1:0]  crc_pos;
	logic [crcfrc_pkg::POS_W-1:0]  total;
	logic [crcfrc_pkg::CRC_W-1:0]  crc_upd;
	logic [crcfrc_pkg::CRC_W-1:0]  got;

	assign crc_pos = {1'b0, len_q} + POS_DATA;
	assign total   = {1'b0, len_q} + crcfrc_pkg::FRAME_OVERHEAD;
	assign crc_upd = crcfrc_pkg::crc_feed(crc_q, rx_byte, cfg.poly);
	assign got     = {rx_byte, crc_lo_q};

	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		crc_d    = crc_q;
		match_d  = match_q;
		crc_lo_d = crc_lo_q;
		res      = '0;
		res.frame_status = crcfrc_pkg::ST_PENDING;
		priority if (abort) begin
			pos_d    = '0;
			len_d    = '0;
			crc_d    = crcfrc_pkg::CRC_INIT;
			match_d  = 1'b1;
			crc_lo_d = '0;
		end else if (pos_q == POS_PFX1) begin
			match_d = (rx_byte == cfg.pfx1);
			pos_d   = POS_PFX2;
		end else if (pos_q == POS_PFX2) begin
			if (rx_byte != cfg.pfx2)
				match_d = 1'b0;
			pos_d = POS_LENHI;
		end else if (pos_q == POS_LENHI) begin
			len_d = {rx_byte, 8'h00};
			crc_d = crc_upd;
			pos_d = POS_LENLO;
		end else if (pos_q == POS_LENLO) begin
			len_d = {len_q[15:8], rx_byte};
			crc_d = crc_upd;
			pos_d = POS_DATA;
		end else if (pos_q < crc_pos) begin
			res.payload_byte  = rx_byte;
			res.payload_valid = 1'b1;
			crc_d = crc_upd;
			pos_d = pos_q + 17'd1;
		end else if (pos_q == crc_pos) begin
			crc_lo_d = rx_byte;
			pos_d    = pos_q + 17'd1;
		end else begin
			res.frame_done = 1'b1;
			priority if (total < cfg.minb)
				res.frame_status = crcfrc_pkg::ST_SHORT;
			else if (!match_q)
				res.frame_status = crcfrc_pkg::ST_PREFIX;
			else if (got != crc_q)
				res.frame_status = crcfrc_pkg::ST_CRC;
			else
				res.frame_status = crcfrc_pkg::ST_OK;
			pos_d    = '0;
			len_d    = '0;
			crc_d    = crcfrc_pkg::CRC_INIT;
			match_d  = 1'b1;
			crc_lo_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			crc_q    <= crcfrc_pkg::CRC_INIT;
			match_q  <= 1'b1;
			crc_lo_q <= '0;
		end else if (step) begin
			pos_q    <= pos_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			match_q  <= match_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/crc16_frame_receive_checker.sv]
// Top level: length-prefixed frame receiver with CRC-16 check and payload pass-through.
//
//  channel   dir  handshake          contents
//  s_axis    in   s_tvalid/s_tready  tdata[7:0] rx_byte, tuser[0] abort
//  m_axis    out  m_tvalid/m_tready  tdata[7:0] payload_byte, tlast frame_done,
//                                    tuser[0] payload_valid, tuser[3:1] frame_status
//  cfg       in   cfg_we             cfg_addr register index, cfg_wdata value
//
// One transaction in gives exactly one transaction out, one per cycle sustained while m_tready
// stays high. Each passes the input register (_s1), then parse + byte-wide CRC into the
// output register (_s2). The frame state advances when the s1 item moves into s2.
// s_tready stays high while the output register is empty or being drained, so a
// stalled output holds at most two transactions in flight.
// arst_n clears valid bits, frame state (CRC 0xFFFF) and config registers to their defaults.
`default_nettype none

module crc16_frame_receive_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// config write port
	input  wire logic                                cfg_we,
	input  wire logic [crcfrc_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  wire logic [crcfrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// receive byte stream
	input  wire logic                                s_tvalid,
	output      logic                                s_tready,
	input  wire logic [7:0]                          s_tdata,  // [7:0] rx_byte
	input  wire logic                                s_tuser,  // [0] abort
	// result stream
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	output      logic [7:0]                          m_tdata,  // [7:0] payload_byte
	output      logic                                m_tlast,  // frame_done
	output      logic [3:0]                          m_tuser   // [0] payload_valid, [3:1] status
);

	crcfrc_pkg::cfg_t    cfg_q;
	crcfrc_pkg::result_t res;
	crcfrc_pkg::result_t res_s2;

	logic       vld_s1, vld_s2;
	logic [7:0] byte_s1;
	logic       abort_s1;
	logic       adv2, step;

	// Register file. Index is 2 bits wide, so every index names a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly <= crcfrc_pkg::CRC_POLY_RST;
			cfg_q.pfx1 <= '0;
			cfg_q.pfx2 <= '0;
			cfg_q.minb <= crcfrc_pkg::MIN_BYTES_RST;
		end else if (cfg_we) begin
			unique case (crcfrc_pkg::reg_idx_t'(cfg_addr))
				crcfrc_pkg::REG_POLY: cfg_q.poly <= cfg_wdata[15:0];
				crcfrc_pkg::REG_PFX1: cfg_q.pfx1 <= cfg_wdata[7:0];
				crcfrc_pkg::REG_PFX2: cfg_q.pfx2 <= cfg_wdata[7:0];
				crcfrc_pkg::REG_MINB: cfg_q.minb <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Output register can take a new transaction when empty or being drained.
	assign adv2     = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv2;
	assign step     = vld_s1 && adv2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			abort_s1 <= s_tuser;
		end
	end

	crcfrc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.step    (step),
		.rx_byte (byte_s1),
		.abort   (abort_s1),
		.res     (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res;
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2.payload_byte;
	assign m_tlast  = res_s2.frame_done;
	assign m_tuser  = {res_s2.frame_status, res_s2.payload_valid};

endmodule

`default_nettype wire

[hw/rtl/crcfrc_sva.sv]
// Port-level checker for the frame receiver, bound to the top level.
`default_nettype none

module crcfrc_sva (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic [3:0] m_tuser
);

	// frame end carries a final status and never a payload byte
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[3:1] != 3'd0 && !m_tuser[0])
		else $error("frame end without status or with payload");

	// mid-frame transactions report pending
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[3:1] == 3'd0)
		else $error("status reported outside frame end");

	// non-payload transactions carry a zero byte
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("data on non-payload transaction");

	// status code within its defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[3:1] <= 3'd4)
		else $error("undefined status code");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind crc16_frame_receive_checker crcfrc_sva u_crcfrc_sva (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
